@@ design/stbs_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// stbs_pkg
// Shared types and constants for the sorted table binary search block.
// ----------------------------------------------------------------------------
package stbs_pkg;

  // Field widths of the item ports.
  localparam int INDEX_W = 10;
  localparam int VALUE_W = 32;
  // Working bounds are signed and wide enough to hold -1 and one past the last index.
  localparam int BOUND_W = INDEX_W + 2;

  localparam int TABLE_DEPTH_DEFAULT = 1024;

  // Item kinds.
  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_SEARCH = 1'b1;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_COMPARE,
    ST_FINISH
  } state_t;

  // Commands from the sequencer to the bound unit.
  typedef struct packed {
    logic start;  // load key and bounds from the accepted item
    logic probe;  // latch mid and issue the table read
    logic step;   // narrow the range after a miss
  } bound_ctl_t;

  // Status from the bound unit to the sequencer.
  typedef struct packed {
    logic               empty;  // lower bound above upper bound
    logic               hit;    // key equals the probed entry
    logic [INDEX_W-1:0] mid;    // index of the last probe
  } bound_sts_t;

endpackage
`default_nettype wire

@@ design/stbs_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// stbs_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module stbs_ram #(
  parameter int WIDTH = stbs_pkg::VALUE_W,
  parameter int DEPTH = stbs_pkg::TABLE_DEPTH_DEFAULT
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ design/stbs_bounds.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// stbs_bounds
// Holds the search key and working bounds, forms the probe index and
// compares the key with the entry read back from the table.
// ----------------------------------------------------------------------------
module stbs_bounds #(
  parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire stbs_pkg::bound_ctl_t             ctl,
  input  wire logic signed [stbs_pkg::VALUE_W-1:0] value,
  input  wire logic [stbs_pkg::INDEX_W-1:0]     low_bound,
  input  wire logic [stbs_pkg::INDEX_W-1:0]     high_bound,
  input  wire logic [stbs_pkg::VALUE_W-1:0]     rdata,
  output logic      [$clog2(TABLE_DEPTH)-1:0]   raddr,
  output stbs_pkg::bound_sts_t                  sts
);
  import stbs_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int EW = (AW > INDEX_W) ? AW : INDEX_W;

  logic signed [BOUND_W-1:0] lo;
  logic signed [BOUND_W-1:0] hi;
  logic signed [VALUE_W-1:0] key;
  logic [INDEX_W-1:0]        mid;
  logic                      oob;

  logic signed [BOUND_W:0]   sum;
  logic [INDEX_W-1:0]        mid_calc;
  logic [EW-1:0]             mid_ext;
  logic signed [VALUE_W-1:0] entry;
  logic signed [BOUND_W-1:0] mid_s;

  // Probe index; only used while both bounds are in range and ordered.
  assign sum      = {lo[BOUND_W-1], lo} + {hi[BOUND_W-1], hi};
  assign mid_calc = sum[INDEX_W:1];
  assign mid_ext  = EW'(mid_calc);
  assign raddr    = mid_ext[AW-1:0];

  // Compare against the entry; indexes past the table read as zero.
  assign entry = oob ? '0 : $signed(rdata);
  assign mid_s = $signed({{(BOUND_W-INDEX_W){1'b0}}, mid});

  assign sts.empty = (lo > hi);
  assign sts.hit   = (key == entry);
  assign sts.mid   = mid;

  // Working bounds persist between searches.
  always_ff @(posedge clk) begin
    if (rst) begin
      lo <= '0;
      hi <= '0;
    end else if (ctl.start) begin
      lo <= $signed({{(BOUND_W-INDEX_W){1'b0}}, low_bound});
      hi <= $signed({{(BOUND_W-INDEX_W){1'b0}}, high_bound});
    end else if (ctl.step) begin
      if (key < entry) begin
        hi <= mid_s - BOUND_W'(1);
      end else begin
        lo <= mid_s + BOUND_W'(1);
      end
    end
  end

  // Key and probe index.
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      key <= value;
    end
    if (ctl.probe) begin
      mid <= mid_calc;
      oob <= (32'(mid_calc) >= TABLE_DEPTH);
    end
  end

endmodule
`default_nettype wire

@@ design/stbs_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// stbs_ctrl
// Sequencer for table writes and searches, with the result output register.
// ----------------------------------------------------------------------------
module stbs_ctrl #(
  parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         kind,
  input  wire logic [stbs_pkg::INDEX_W-1:0] write_index,
  output logic                              we,
  output logic [$clog2(TABLE_DEPTH)-1:0]    waddr,
  output stbs_pkg::bound_ctl_t              ctl,
  input  wire stbs_pkg::bound_sts_t         sts,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              found,
  output logic [stbs_pkg::INDEX_W-1:0]      position
);
  import stbs_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int EW = (AW > INDEX_W) ? AW : INDEX_W;

  state_t             state;
  state_t             state_next;
  logic               accept;
  logic               out_free;
  logic               res_load;
  logic               res_found_next;
  logic               res_found;
  logic [INDEX_W-1:0] res_pos;
  logic [EW-1:0]      widx_ext;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Table writes happen at acceptance; indexes past the table are dropped.
  assign widx_ext = EW'(write_index);
  assign waddr    = widx_ext[AW-1:0];
  assign we       = accept && (kind == KIND_WRITE) && (32'(write_index) < TABLE_DEPTH);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && (kind == KIND_SEARCH)) begin
          state_next = ST_PROBE;
        end
      end
      ST_PROBE: begin
        state_next = sts.empty ? ST_FINISH : ST_COMPARE;
      end
      ST_COMPARE: begin
        state_next = sts.hit ? ST_FINISH : ST_PROBE;
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer. Items are held off while reset is applied.
  always_comb begin
    in_stall       = 1'b1;
    ctl            = '0;
    res_load       = 1'b0;
    res_found_next = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall  = rst;
        ctl.start = in_valid && (kind == KIND_SEARCH);
      end
      ST_PROBE: begin
        ctl.probe = !sts.empty;
        res_load  = sts.empty;
      end
      ST_COMPARE: begin
        ctl.step       = !sts.hit;
        res_load       = sts.hit;
        res_found_next = 1'b1;
      end
      ST_FINISH: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Result held until the output register is free.
  always_ff @(posedge clk) begin
    if (res_load) begin
      res_found <= res_found_next;
      res_pos   <= res_found_next ? sts.mid : '0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_free) begin
      found    <= res_found;
      position <= res_pos;
    end
  end

endmodule
`default_nettype wire

@@ design/sorted_table_binary_search.sv @@
`default_nettype none
// A write item gives no result. A search item gives one result after its
// probes; each probe is one table read plus one compare. One search at a
// time; writes every cycle while no search runs.
// Reset clears the sequencer, bounds and output valid; table contents are
// undefined until written and are not cleared.
// ----------------------------------------------------------------------------
// sorted_table_binary_search
// Sorted table of signed entries in a synchronous RAM, searched by bisection.
// ----------------------------------------------------------------------------
module sorted_table_binary_search #(
  parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEFAULT
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic                               kind,
  input  wire logic [stbs_pkg::INDEX_W-1:0]       write_index,
  input  wire logic signed [stbs_pkg::VALUE_W-1:0] value,
  input  wire logic [stbs_pkg::INDEX_W-1:0]       low_bound,
  input  wire logic [stbs_pkg::INDEX_W-1:0]       high_bound,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic                                    found,
  output logic [stbs_pkg::INDEX_W-1:0]            position
);
  import stbs_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);

  logic               we;
  logic [AW-1:0]      waddr;
  logic [AW-1:0]      raddr;
  logic [VALUE_W-1:0] rdata;
  bound_ctl_t         ctl;
  bound_sts_t         sts;

  // Sequencer and output register.
  stbs_ctrl #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .write_index(write_index),
    .we         (we),
    .waddr      (waddr),
    .ctl        (ctl),
    .sts        (sts),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .found      (found),
    .position   (position)
  );

  // Key, bounds and compare.
  stbs_bounds #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_bounds (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .value     (value),
    .low_bound (low_bound),
    .high_bound(high_bound),
    .rdata     (rdata),
    .raddr     (raddr),
    .sts       (sts)
  );

  // Table storage. Writes are only taken while no search runs, so a probe
  // never overlaps a write.
  stbs_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(value),
    .re   (ctl.probe),
    .raddr(raddr),
    .rdata(rdata)
  );

endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sorted table binary search block. Table writes
// and searches are driven through the item port, and every search is predicted
// against a shadow copy of the table. Each result is checked field by field,
// in order, while both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  import stbs_pkg::*;

  localparam int TABLE_SIZE    = TABLE_DEPTH_DEFAULT;
  localparam int RANDOM_ITEMS  = 400;
  localparam int SETTLE_CYCLES = 60;
  localparam int CYCLE_LIMIT   = 500000;

  typedef struct packed {
    logic               found;
    logic [INDEX_W-1:0] position;
  } search_result_t;

  logic                      clk         = 1'b0;
  logic                      rst         = 1'b1;
  logic                      in_valid    = 1'b0;
  logic                      in_stall;
  logic                      kind        = KIND_WRITE;
  logic [INDEX_W-1:0]        write_index = '0;
  logic signed [VALUE_W-1:0] value       = '0;
  logic [INDEX_W-1:0]        low_bound   = '0;
  logic [INDEX_W-1:0]        high_bound  = '0;
  logic                      out_valid;
  logic                      out_stall   = 1'b0;
  logic                      found;
  logic [INDEX_W-1:0]        position;

  // Shadow of the table contents and of which entries hold a written value.
  logic signed [VALUE_W-1:0] shadow_table [TABLE_SIZE];
  bit                        shadow_written [TABLE_SIZE];

  search_result_t expected_results [$];
  int             items_sent    = 0;
  int             mismatches    = 0;
  int             cycle_count   = 0;
  int             send_idle_max = 0;
  int             recv_idle_max = 0;

  sorted_table_binary_search #(
    .TABLE_DEPTH(TABLE_SIZE)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .write_index(write_index),
    .value      (value),
    .low_bound  (low_bound),
    .high_bound (high_bound),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .found      (found),
    .position   (position)
  );

  always #1 clk = ~clk;

  // Hard stop in case the block hangs or a result never arrives.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: cycle limit reached with %0d results outstanding", $time,
               expected_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Bisection over the shadow table. Also reports whether any probe lands on
  // an entry that was never written, so the stimulus can steer clear of it.
  function automatic search_result_t bisect_table(input logic signed [VALUE_W-1:0] key,
                                                  input int lo_in, input int hi_in,
                                                  output bit unwritten_probe);
    int             lo;
    int             hi;
    int             mid;
    search_result_t res;
    lo = lo_in;
    hi = hi_in;
    res = '0;
    unwritten_probe = 1'b0;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (!shadow_written[mid]) unwritten_probe = 1'b1;
      if (key == shadow_table[mid]) begin
        res.found = 1'b1;
        res.position = mid[INDEX_W-1:0];
        break;
      end
      if (key < shadow_table[mid]) hi = mid - 1;
      else lo = mid + 1;
    end
    return res;
  endfunction

  function automatic bit search_is_safe(input logic signed [VALUE_W-1:0] key,
                                        input int lo, input int hi);
    bit             unwritten;
    search_result_t res;
    res = bisect_table(key, lo, hi, unwritten);
    return !unwritten;
  endfunction

  // Sends one item after a random gap and updates the prediction once the
  // block takes it. Valid stays high on return so a back-to-back item can
  // follow straight after it.
  task automatic send_item(input logic k, input logic [INDEX_W-1:0] idx,
                           input logic signed [VALUE_W-1:0] val,
                           input logic [INDEX_W-1:0] lo, input logic [INDEX_W-1:0] hi);
    int             gap;
    bit             unwritten;
    search_result_t res;
    gap = $urandom_range(0, send_idle_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    kind        <= k;
    write_index <= idx;
    value       <= val;
    low_bound   <= lo;
    high_bound  <= hi;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (k == KIND_WRITE) begin
      shadow_table[idx] = val;
      shadow_written[idx] = 1'b1;
    end else begin
      res = bisect_table(val, int'(lo), int'(hi), unwritten);
      expected_results.push_back(res);
    end
  endtask

  task automatic send_write(input int idx, input logic signed [VALUE_W-1:0] val);
    send_item(KIND_WRITE, idx[INDEX_W-1:0], val,
              INDEX_W'($urandom_range(0, TABLE_SIZE - 1)),
              INDEX_W'($urandom_range(0, TABLE_SIZE - 1)));
  endtask

  task automatic send_search(input logic signed [VALUE_W-1:0] key, input int lo, input int hi);
    send_item(KIND_SEARCH, INDEX_W'($urandom_range(0, TABLE_SIZE - 1)), key,
              lo[INDEX_W-1:0], hi[INDEX_W-1:0]);
  endtask

  // Holds the sender off until every outstanding result has been checked.
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Chooses how hard each side idles: not at all, lightly, or heavily.
  task automatic pick_idling();
    case ($urandom_range(0, 2))
      0: send_idle_max = 0;
      1: send_idle_max = 2;
      default: send_idle_max = 12;
    endcase
    case ($urandom_range(0, 2))
      0: recv_idle_max = 0;
      1: recv_idle_max = 2;
      default: recv_idle_max = 12;
    endcase
  endtask

  // Extreme values at both ends of the index space, hits and misses.
  task automatic test_table_extremes();
    send_idle_max = 3;
    recv_idle_max = 3;
    send_write(0, 32'sh8000_0000);
    send_write(1, -32'sd1000);
    send_write(2, -32'sd1);
    send_write(3, 32'sd0);
    send_write(4, 32'sd1);
    send_write(5, 32'sh7fff_ffff);
    send_write(1022, 32'sd5);
    send_write(TABLE_SIZE - 1, 32'sh7fff_ffff);
    send_search(32'sh8000_0000, 0, 5);
    send_search(32'sh7fff_ffff, 0, 5);
    send_search(32'sd0, 0, 5);
    send_search(-32'sd5, 0, 5);
    send_search(32'sd2, 0, 5);
    send_search(32'sh7fff_ffff, TABLE_SIZE - 1, TABLE_SIZE - 1);
    send_search(32'sd5, 1022, TABLE_SIZE - 1);
    send_search(32'sd6, 1022, TABLE_SIZE - 1);
  endtask

  // Empty ranges end at once with no probe; a one-entry range probes once.
  task automatic test_range_corners();
    send_search(32'sd0, 5, 4);
    send_search(32'sd0, TABLE_SIZE - 1, 0);
    send_search(32'sd0, 3, 3);
  endtask

  // Out-of-order contents: the upper bound falls below zero on one search,
  // and a present key is missed on the other.
  task automatic test_unsorted_table();
    send_write(0, 32'sd100);
    send_search(32'sd50, 0, 0);
    send_search(32'sd100, 0, 5);
  endtask

  // Writes an ascending run, with repeats possible, over one window.
  task automatic fill_sorted_window(input int base, input int len);
    longint          step_max;
    longint unsigned span;
    longint unsigned raw;
    longint          entry;
    case ($urandom_range(0, 3))
      0: step_max = 1;
      1: step_max = 8;
      2: step_max = 5000;
      default: step_max = 64'sd1 << 24;
    endcase
    span = (64'd1 << 32) - longint'(len) * step_max;
    raw = {$urandom, $urandom};
    entry = -(64'sd1 << 31) + longint'(raw % span);
    for (int i = 0; i < len; i++) begin
      send_write(base + i, entry[VALUE_W-1:0]);
      entry += $urandom_range(0, int'(step_max));
    end
  endtask

  // One random item aimed at a filled window: mostly searches for present
  // keys and near misses, plus random keys, empty ranges, wide ranges and stray writes.
  task automatic random_window_item(input int wlo, input int whi);
    int                        pick;
    int                        idx;
    int                        lo;
    int                        hi;
    logic signed [VALUE_W-1:0] key;
    pick = $urandom_range(0, 99);
    idx = $urandom_range(wlo, whi);
    if ($urandom_range(0, 1)) begin
      lo = wlo;
      hi = whi;
    end else begin
      lo = $urandom_range(wlo, idx);
      hi = $urandom_range(idx, whi);
    end
    key = shadow_table[idx];
    if (pick < 50) begin
      send_search(key, lo, hi);
    end else if (pick < 70) begin
      send_search($urandom_range(0, 1) ? key + 1 : key - 1, lo, hi);
    end else if (pick < 78) begin
      send_search($urandom, lo, hi);
    end else if (pick < 86) begin
      lo = $urandom_range(1, TABLE_SIZE - 1);
      hi = $urandom_range(0, lo - 1);
      send_search($urandom, lo, hi);
    end else if (pick < 94) begin
      // Wide range anywhere; fall back to the window if it would touch
      // entries that were never written.
      lo = $urandom_range(0, TABLE_SIZE - 1);
      hi = $urandom_range(lo, TABLE_SIZE - 1);
      if (!search_is_safe(key, lo, hi)) begin
        lo = wlo;
        hi = whi;
      end
      send_search(key, lo, hi);
    end else begin
      send_write(idx, $urandom);
    end
  endtask

  // Random windows across the whole table, each filled and then searched.
  task automatic test_random_search();
    int first_item;
    int window_count;
    int base;
    int len;
    first_item = items_sent;
    window_count = 0;
    while (items_sent - first_item < RANDOM_ITEMS) begin
      pick_idling();
      if ($urandom_range(0, 9) == 0) len = $urandom_range(64, 128);
      else len = $urandom_range(1, 40);
      if ($urandom_range(0, 4) == 0) base = TABLE_SIZE - len;
      else base = $urandom_range(0, TABLE_SIZE - len);
      fill_sorted_window(base, len);
      repeat ($urandom_range(4, 16)) random_window_item(base, base + len - 1);
      window_count++;
      if (window_count % 4 == 0) wait_results_drained();
    end
  endtask

  // Receiver stall: a random hold before each result, then ready until one
  // is taken.
  initial begin : result_stall
    int hold;
    @(posedge clk);
    forever begin
      hold = $urandom_range(0, recv_idle_max);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!(out_valid && !rst)) @(posedge clk);
    end
  end

  // Compares every accepted result with the oldest prediction.
  initial begin : result_checker
    search_result_t want;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with none expected: found=%0b position=%0d", $time,
                   found, position);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (found !== want.found) begin
            $display("%0t: found mismatch: expected %0b, actual %0b", $time, want.found,
                     found);
            mismatches++;
          end
          if (position !== want.position) begin
            $display("%0t: position mismatch: expected %0d, actual %0d", $time,
                     want.position, position);
            mismatches++;
          end
        end
      end
    end
  end

  initial begin : test_sequence
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_table_extremes();
    test_range_corners();
    test_unsorted_table();
    wait_results_drained();
    test_random_search();
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ filelist.f @@
design/stbs_pkg.sv
design/stbs_ram.sv
design/stbs_bounds.sv
design/stbs_ctrl.sv
design/sorted_table_binary_search.sv
sim/tb_top.sv
